// ===== hw/rtl/tifrt_pkg.sv =====
// shared types and constants for the tiff ifd rating tag scanner
package tifrt_pkg;

  // directory limits and the tag being looked for
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam logic [15:0] RATING_TAG  = 16'h4746;
  localparam int unsigned ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);

  // header layout
  localparam logic [31:0] MAGIC_LE     = 32'h4949_2A00;
  localparam logic [31:0] MAGIC_BE     = 32'h4D4D_002A;
  localparam logic [31:0] FIRST_IFD    = 32'd8;
  localparam logic [31:0] MAGIC_POS    = 32'd3;
  localparam logic [31:0] IFD_PTR_POS  = 32'd7;
  localparam int unsigned ENTRY_BYTES  = 12;
  localparam int unsigned FILL_W       = $clog2(ENTRY_BYTES);

  // field types of an ifd entry
  localparam logic [15:0] TYPE_BYTE  = 16'd1;
  localparam logic [15:0] TYPE_SHORT = 16'd3;
  localparam logic [15:0] TYPE_LONG  = 16'd4;

  // configuration port
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic [0:0] {
    REG_MIN_RATING = 1'b0,
    REG_MAX_RATING = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_IFD     = 3'd2,
    ST_BAD_ENTRIES = 3'd3,
    ST_TRUNCATED   = 3'd4,
    ST_NO_TAG      = 3'd5,
    ST_BAD_COUNT   = 3'd6,
    ST_BAD_TYPE    = 3'd7
  } scan_status_t;

  typedef struct packed {
    logic                rating_found;
    logic signed [7:0]   rating_value;
    scan_status_t        scan_status;
  } result_t;

endpackage

// ===== hw/rtl/tifrt_if.sv =====
// valid/ready channel interfaces for byte input and scan results
interface tifrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface tifrt_out_if;
  import tifrt_pkg::*;

  logic              valid;
  logic              ready;
  logic              rating_found;
  logic signed [7:0] rating_value;
  scan_status_t      scan_status;

  modport source(output valid, rating_found, rating_value, scan_status, input ready);
  modport sink(input valid, rating_found, rating_value, scan_status, output ready);
endinterface

// ===== hw/rtl/tiff_ifd_rating_tag_scanner_unit.sv =====
// tiff ifd rating tag scanner: byte parser, range registers and result buffer
// a result enters the output buffer with the transfer of the byte that decides it
// throughput: one byte per cycle unless the buffer is full; one parse update per byte
// results go through a two-entry output buffer, so bytes keep flowing while a result waits
// reset (rst_n low, synchronous): parser back at offset 0, buffer empty, min 0, max 5
// the byte after an end_of_file byte starts a new file; registers keep their values
module tiff_ifd_rating_tag_scanner_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  tifrt_in_if.sink                            in_chan,
  tifrt_out_if.source                         out_chan,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tifrt_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tifrt_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tifrt_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import tifrt_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } phase_t;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(ENTRY_BYTES - 1);

  // byte-order aware field assembly
  function automatic logic [15:0] get16(input logic le, input logic [7:0] b0,
                                        input logic [7:0] b1);
    return le ? {b1, b0} : {b0, b1};
  endfunction

  function automatic logic [31:0] get32(input logic le, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3);
    return le ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [7:0] min_rating_r;
  logic signed [7:0] max_rating_r;
  logic              cfg_write;
  reg_index_t        cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = reg_index_t'(cfg_paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rating_r <= 8'sd0;
      max_rating_r <= 8'sd5;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_MIN_RATING: min_rating_r <= cfg_pwdata[7:0];
        REG_MAX_RATING: max_rating_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MIN_RATING: cfg_prdata = {{(CFG_DATA_W-8){min_rating_r[7]}}, min_rating_r};
      REG_MAX_RATING: cfg_prdata = {{(CFG_DATA_W-8){max_rating_r[7]}}, max_rating_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // parse state
  // ---------------------------------------------------------------------------
  phase_t                 phase_r,         phase_nxt;
  logic                   little_endian_r, little_endian_nxt;
  logic [31:0]            byte_pos_r,      byte_pos_nxt;
  logic [31:0]            header_shift_r,  header_shift_nxt;
  logic [31:0]            ifd_offset_r,    ifd_offset_nxt;
  logic [ENTRY_CNT_W-1:0] entries_total_r, entries_total_nxt;
  logic [ENTRY_CNT_W-1:0] entry_index_r,   entry_index_nxt;
  logic [FILL_W-1:0]      entry_fill_r,    entry_fill_nxt;
  scan_status_t           pending_r,       pending_nxt;
  logic [7:0]             pend_rating_r,   pend_rating_nxt;

  // bytes 0..10 of the current entry; the last byte is used straight from the input
  logic [7:0]             entry_bytes_r [ENTRY_BYTES-1];
  logic                   byte_we;

  logic                   in_fire;
  logic [7:0]             in_byte;
  logic [31:0]            shifted;
  logic [31:0]            ifd_calc;
  logic [15:0]            count16;

  // entry examination
  logic [15:0]            ent_tag;
  logic [15:0]            ent_type;
  logic [31:0]            ent_count;
  logic [31:0]            ent_value;
  logic                   ent_in_range;
  scan_status_t           exam_status;

  // result of this byte
  logic                   res_valid;
  result_t                res;

  assign in_byte  = in_chan.data_byte;
  assign shifted  = {header_shift_r[23:0], in_byte};
  assign ifd_calc = little_endian_r ? {shifted[7:0], shifted[15:8], shifted[23:16],
                                       shifted[31:24]} : shifted;
  assign count16  = get16(little_endian_r, entry_bytes_r[0], in_byte);

  assign ent_tag   = get16(little_endian_r, entry_bytes_r[0], entry_bytes_r[1]);
  assign ent_type  = get16(little_endian_r, entry_bytes_r[2], entry_bytes_r[3]);
  assign ent_count = get32(little_endian_r, entry_bytes_r[4], entry_bytes_r[5],
                           entry_bytes_r[6], entry_bytes_r[7]);

  always_comb begin
    case (ent_type)
      TYPE_BYTE:  ent_value = {24'd0, entry_bytes_r[8]};
      TYPE_SHORT: ent_value = {16'd0, get16(little_endian_r, entry_bytes_r[8],
                                            entry_bytes_r[9])};
      default:    ent_value = get32(little_endian_r, entry_bytes_r[8], entry_bytes_r[9],
                                    entry_bytes_r[10], in_byte);
    endcase
  end

  // unsigned value against signed bounds, compared as 33-bit signed numbers
  assign ent_in_range = ($signed({1'b0, ent_value}) >= 33'(min_rating_r)) &&
                        ($signed({1'b0, ent_value}) <= 33'(max_rating_r));

  always_comb begin
    exam_status = ST_NO_TAG;
    if (ent_tag == RATING_TAG) begin
      if (ent_count != 32'd1) begin
        exam_status = ST_BAD_COUNT;
      end else if (ent_type != TYPE_BYTE && ent_type != TYPE_SHORT &&
                   ent_type != TYPE_LONG) begin
        exam_status = ST_BAD_TYPE;
      end else if (ent_in_range) begin
        exam_status = ST_FOUND;
      end
    end
  end

  // next state for one byte
  always_comb begin
    phase_nxt         = phase_r;
    little_endian_nxt = little_endian_r;
    byte_pos_nxt      = (&byte_pos_r) ? byte_pos_r : byte_pos_r + 32'd1;
    header_shift_nxt  = header_shift_r;
    ifd_offset_nxt    = ifd_offset_r;
    entries_total_nxt = entries_total_r;
    entry_index_nxt   = entry_index_r;
    entry_fill_nxt    = entry_fill_r;
    pending_nxt       = pending_r;
    pend_rating_nxt   = pend_rating_r;
    byte_we           = 1'b0;
    res_valid         = 1'b0;
    res.scan_status   = ST_FOUND;
    res.rating_found  = 1'b0;
    res.rating_value  = 8'sd0;

    unique case (phase_r)
      PH_HEADER: begin
        header_shift_nxt = shifted;
        if (byte_pos_r == MAGIC_POS) begin
          if (shifted == MAGIC_LE) begin
            little_endian_nxt = 1'b1;
          end else if (shifted == MAGIC_BE) begin
            little_endian_nxt = 1'b0;
          end else begin
            res_valid       = 1'b1;
            res.scan_status = ST_BAD_MAGIC;
            phase_nxt       = PH_DONE;
          end
        end else if (byte_pos_r == IFD_PTR_POS) begin
          ifd_offset_nxt   = ifd_calc;
          header_shift_nxt = '0;
          if (ifd_calc < FIRST_IFD) begin
            res_valid       = 1'b1;
            res.scan_status = ST_BAD_IFD;
            phase_nxt       = PH_DONE;
          end else begin
            phase_nxt = (ifd_calc == FIRST_IFD) ? PH_COUNT : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        // skip until the byte just before the directory
        if ({1'b0, byte_pos_r} + 33'd1 >= {1'b0, ifd_offset_r}) begin
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (!entry_fill_r[0]) begin
          byte_we        = 1'b1;
          entry_fill_nxt = FILL_W'(1);
        end else begin
          entry_fill_nxt    = '0;
          entries_total_nxt = count16[ENTRY_CNT_W-1:0];
          if (count16 == 16'd0 || count16 > 16'(MAX_ENTRIES)) begin
            res_valid       = 1'b1;
            res.scan_status = ST_BAD_ENTRIES;
            phase_nxt       = PH_DONE;
          end else begin
            phase_nxt = PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        if (entry_fill_r != FILL_LAST) begin
          byte_we        = 1'b1;
          entry_fill_nxt = entry_fill_r + FILL_W'(1);
        end else begin
          entry_fill_nxt = '0;
          // once decided, later entries are only counted
          if (pending_r == ST_NO_TAG) begin
            pending_nxt = exam_status;
            if (exam_status == ST_FOUND) begin
              pend_rating_nxt = ent_value[7:0];
            end
          end
          entry_index_nxt = entry_index_r + ENTRY_CNT_W'(1);
          if (entry_index_nxt >= entries_total_r) begin
            res_valid        = 1'b1;
            res.scan_status  = pending_nxt;
            res.rating_found = (pending_nxt == ST_FOUND);
            res.rating_value = (pending_nxt == ST_FOUND) ? pend_rating_nxt : 8'sd0;
            phase_nxt        = PH_DONE;
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (in_chan.end_of_file) begin
      // early end: nothing reported yet for this file
      if (!res_valid && phase_r != PH_DONE) begin
        res_valid        = 1'b1;
        res.scan_status  = ST_TRUNCATED;
        res.rating_found = 1'b0;
        res.rating_value = 8'sd0;
      end
      phase_nxt         = PH_HEADER;
      little_endian_nxt = 1'b0;
      byte_pos_nxt      = '0;
      header_shift_nxt  = '0;
      ifd_offset_nxt    = '0;
      entries_total_nxt = '0;
      entry_index_nxt   = '0;
      entry_fill_nxt    = '0;
      pending_nxt       = ST_NO_TAG;
      pend_rating_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      little_endian_r <= 1'b0;
      byte_pos_r      <= '0;
      header_shift_r  <= '0;
      ifd_offset_r    <= '0;
      entries_total_r <= '0;
      entry_index_r   <= '0;
      entry_fill_r    <= '0;
      pending_r       <= ST_NO_TAG;
      pend_rating_r   <= '0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      little_endian_r <= little_endian_nxt;
      byte_pos_r      <= byte_pos_nxt;
      header_shift_r  <= header_shift_nxt;
      ifd_offset_r    <= ifd_offset_nxt;
      entries_total_r <= entries_total_nxt;
      entry_index_r   <= entry_index_nxt;
      entry_fill_r    <= entry_fill_nxt;
      pending_r       <= pending_nxt;
      pend_rating_r   <= pend_rating_nxt;
    end
  end

  // entry byte store, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && byte_we) begin
      entry_bytes_r[entry_fill_r] <= in_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // two-entry result buffer: head in slot0, input stalls only when both are full
  // ---------------------------------------------------------------------------
  result_t    slot0_r;
  result_t    slot1_r;
  logic [1:0] fill_cnt_r;
  logic       push;
  logic       pop;

  assign in_chan.ready = (fill_cnt_r != 2'd2);
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign push          = in_fire & res_valid;
  assign pop           = out_chan.valid & out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else begin
      fill_cnt_r <= fill_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !push) begin
      slot0_r <= slot1_r;
    end else if (push && !pop) begin
      if (fill_cnt_r == 2'd0) begin
        slot0_r <= res;
      end else begin
        slot1_r <= res;
      end
    end else if (push && pop) begin
      if (fill_cnt_r == 2'd1) begin
        slot0_r <= res;
      end else begin
        slot0_r <= slot1_r;
        slot1_r <= res;
      end
    end
  end

  assign out_chan.valid        = (fill_cnt_r != 2'd0);
  assign out_chan.rating_found = slot0_r.rating_found;
  assign out_chan.rating_value = slot0_r.rating_value;
  assign out_chan.scan_status  = slot0_r.scan_status;

endmodule

// ===== dv/tifrt_scan_checker.sv =====
// scoreboard for the rating tag scanner: mirrors the byte parser and checks every result
module tifrt_scan_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  tifrt_in_if                              in_chan,
  tifrt_out_if                             out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic                             cfg_pready,
  input  logic [tifrt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tifrt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                               open_verdicts,
  output int                               mismatch_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import tifrt_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } parse_phase_t;

  logic signed [7:0] min_rating;
  logic signed [7:0] max_rating;

  parse_phase_t      phase;
  logic              little_end;
  logic [32:0]       pos;
  logic [31:0]       hdr_shift;
  logic [31:0]       ifd_ptr;
  logic [15:0]       dir_total;
  logic [15:0]       dir_idx;
  logic [7:0]        ent [ENTRY_BYTES];
  int unsigned       ent_fill;
  scan_status_t      verdict;
  logic [7:0]        verdict_rating;
  logic              verdict_sent;

  result_t           awaited_results [$];

  function automatic logic [15:0] field16(input int off);
    return little_end ? {ent[off+1], ent[off]} : {ent[off], ent[off+1]};
  endfunction

  function automatic logic [31:0] field32(input int off);
    return little_end ? {ent[off+3], ent[off+2], ent[off+1], ent[off]}
                      : {ent[off], ent[off+1], ent[off+2], ent[off+3]};
  endfunction

  function automatic void clear_file();
    phase          = PH_HEADER;
    little_end     = 1'b0;
    pos            = '0;
    hdr_shift      = '0;
    ifd_ptr        = '0;
    dir_total      = '0;
    dir_idx        = '0;
    ent_fill       = 0;
    verdict        = ST_NO_TAG;
    verdict_rating = '0;
    verdict_sent   = 1'b0;
    foreach (ent[k]) ent[k] = '0;
  endfunction

  function automatic void deliver(input scan_status_t st, input logic [7:0] rating);
    result_t r;
    r.rating_found = (st == ST_FOUND);
    r.rating_value = (st == ST_FOUND) ? rating : 8'sd0;
    r.scan_status  = st;
    awaited_results.insert(awaited_results.size(), r);
    verdict_sent = 1'b1;
    phase        = PH_DONE;
  endfunction

  function automatic void examine_entry();
    logic [15:0] kind;
    longint      val;
    if (field16(0) != RATING_TAG) return;
    kind = field16(2);
    if (field32(4) != 32'd1) begin
      verdict = ST_BAD_COUNT;
      return;
    end
    if (kind == TYPE_BYTE) begin
      val = {56'd0, ent[8]};
    end else if (kind == TYPE_SHORT) begin
      val = {48'd0, field16(8)};
    end else if (kind == TYPE_LONG) begin
      val = {32'd0, field32(8)};
    end else begin
      verdict = ST_BAD_TYPE;
      return;
    end
    // inverted range admits nothing
    if (val >= longint'(min_rating) && val <= longint'(max_rating)) begin
      verdict        = ST_FOUND;
      verdict_rating = val[7:0];
    end
  endfunction

  function automatic void advance_parser(input logic [7:0] b, input logic eof);
    case (phase)
      PH_HEADER: begin
        hdr_shift = {hdr_shift[23:0], b};
        if (pos == MAGIC_POS) begin
          if (hdr_shift == MAGIC_LE) little_end = 1'b1;
          else if (hdr_shift == MAGIC_BE) little_end = 1'b0;
          else deliver(ST_BAD_MAGIC, '0);
        end else if (pos == IFD_PTR_POS) begin
          ifd_ptr = little_end ? {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16],
                                  hdr_shift[31:24]} : hdr_shift;
          hdr_shift = '0;
          if (ifd_ptr < FIRST_IFD) deliver(ST_BAD_IFD, '0);
          else phase = (ifd_ptr == FIRST_IFD) ? PH_COUNT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (({1'b0, pos} + 34'd1) >= {2'b00, ifd_ptr}) phase = PH_COUNT;
      end
      PH_COUNT: begin
        ent[ent_fill & 1] = b;
        ent_fill++;
        if (ent_fill >= 2) begin
          ent_fill  = 0;
          dir_total = field16(0);
          if (dir_total == 0 || dir_total > MAX_ENTRIES) deliver(ST_BAD_ENTRIES, '0);
          else phase = PH_ENTRY;
        end
      end
      PH_ENTRY: begin
        if (ent_fill < ENTRY_BYTES) ent[ent_fill] = b;
        ent_fill++;
        if (ent_fill >= ENTRY_BYTES) begin
          ent_fill = 0;
          if (verdict == ST_NO_TAG) examine_entry();
          dir_idx++;
          if (dir_idx >= dir_total) deliver(verdict, verdict_rating);
        end
      end
      default: ;
    endcase
    if (pos != '1) pos++;
    if (eof) begin
      if (!verdict_sent) deliver(ST_TRUNCATED, '0);
      clear_file();
    end
  endfunction

  function automatic void check_result();
    result_t exp_r;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with none awaited: found %0b value %0d status %0d", $time,
               out_chan.rating_found, out_chan.rating_value, out_chan.scan_status);
      mismatch_cnt++;
      return;
    end
    exp_r = awaited_results[0];
    awaited_results.delete(0);
    if (out_chan.rating_found !== exp_r.rating_found) begin
      $display("%0t: rating_found expected %0b actual %0b", $time,
               exp_r.rating_found, out_chan.rating_found);
      mismatch_cnt++;
    end
    if (out_chan.rating_value !== exp_r.rating_value) begin
      $display("%0t: rating_value expected %0d actual %0d", $time,
               exp_r.rating_value, out_chan.rating_value);
      mismatch_cnt++;
    end
    if (out_chan.scan_status !== exp_r.scan_status) begin
      $display("%0t: scan_status expected %0d actual %0d", $time,
               exp_r.scan_status, out_chan.scan_status);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_rating   = 8'sd0;
      max_rating   = 8'sd5;
      mismatch_cnt = 0;
      awaited_results.delete();
      clear_file();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[REG_SEL_BIT] == REG_MAX_RATING) max_rating = cfg_pwdata[7:0];
        else min_rating = cfg_pwdata[7:0];
      end
      if (in_chan.valid && in_chan.ready) advance_parser(in_chan.data_byte, in_chan.end_of_file);
      if (out_chan.valid && out_chan.ready) check_result();
    end
    open_verdicts = awaited_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// testbench top: streams tiff byte files and range settings into the scanner and reports
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tifrt_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tifrt_in_if  in_chan ();
  tifrt_out_if out_chan ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int open_verdicts;
  int mismatch_cnt;

  // idle odds in percent, per side
  int   tx_idle;
  int   rx_idle;
  // long receiver hold-off, started once by the stimulus
  logic hold_go;
  logic hold_rx;

  // the file being built, and its byte order
  logic [7:0] img [$];
  logic       img_le;

  always #5 clk = ~clk;

  tiff_ifd_rating_tag_scanner_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tifrt_scan_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .open_verdicts (open_verdicts),
    .mismatch_cnt  (mismatch_cnt)
  );

  // receiver: random ready at the falling edge, forced low during the hold-off
  always @(negedge clk) begin
    out_chan.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle);
  end

  // hold-off counted here so the sender keeps offering bytes and the block backs up
  initial begin
    hold_rx = 1'b0;
    wait (hold_go);
    @(negedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(negedge clk);
    hold_rx <= 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- file building

  task automatic put8(input logic [7:0] v);
    img.insert(img.size(), v);
  endtask

  task automatic put16(input logic [15:0] v);
    if (img_le) begin
      put8(v[7:0]);
      put8(v[15:8]);
    end else begin
      put8(v[15:8]);
      put8(v[7:0]);
    end
  endtask

  task automatic put32(input logic [31:0] v);
    if (img_le) begin
      put16(v[15:0]);
      put16(v[31:16]);
    end else begin
      put16(v[31:16]);
      put16(v[15:0]);
    end
  endtask

  task automatic pad_bytes(input int n);
    repeat (n) put8(8'($urandom()));
  endtask

  // byte-order mark, 42 and the first ifd offset in the chosen order
  task automatic start_header(input logic le, input logic [31:0] ifd);
    img.delete();
    img_le = le;
    put16(le ? 16'h4949 : 16'h4D4D);
    put16(16'd42);
    put32(ifd);
  endtask

  // 12-byte entry; value sits left-aligned in its 4-byte slot as the type dictates
  task automatic add_entry(input logic [15:0] tag, input logic [15:0] kind,
                           input logic [31:0] cnt, input logic [31:0] val);
    put16(tag);
    put16(kind);
    put32(cnt);
    if (kind == TYPE_BYTE) begin
      put8(val[7:0]);
      pad_bytes(3);
    end else if (kind == TYPE_SHORT) begin
      put16(val[15:0]);
      pad_bytes(2);
    end else begin
      put32(val);
    end
  endtask

  task automatic add_random_entry();
    logic [15:0] tag;
    logic [15:0] kind;
    logic [31:0] cnt;
    logic [31:0] val;
    case ($urandom_range(0, 9))
      0:       tag = 16'h4647;            // rating tag in the wrong byte order
      1, 2, 3: tag = 16'($urandom());
      default: tag = RATING_TAG;
    endcase
    case ($urandom_range(0, 9))
      0:       kind = 16'($urandom());
      1:       kind = 16'($urandom_range(0, 8));
      2, 3, 4: kind = TYPE_BYTE;
      5, 6:    kind = TYPE_SHORT;
      default: kind = TYPE_LONG;
    endcase
    cnt = ($urandom_range(0, 9) == 0) ? $urandom() : 32'd1;
    case ($urandom_range(0, 3))
      0:       val = $urandom_range(0, 7);
      1:       val = $urandom_range(0, 255);
      2:       val = $urandom_range(120, 135);
      default: val = $urandom();
    endcase
    add_entry(tag, kind, cnt, val);
  endtask

  // mostly well-formed files with random content, some broken or cut short
  task automatic build_random_file(output int cut);
    logic [31:0] ifd;
    logic [15:0] n_ent;
    int          k;
    case ($urandom_range(0, 19))
      0:       ifd = $urandom_range(0, 7);
      1:       ifd = $urandom();
      default: ifd = FIRST_IFD + $urandom_range(0, 6);
    endcase
    start_header($urandom_range(0, 1), ifd);
    if ($urandom_range(0, 19) == 0) begin
      k = $urandom_range(0, 3);
      img[k] = img[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (ifd > FIRST_IFD && ifd < FIRST_IFD + 7) pad_bytes(ifd - FIRST_IFD);
    case ($urandom_range(0, 24))
      0:       n_ent = 16'd0;
      1:       n_ent = 16'($urandom_range(MAX_ENTRIES + 1, 65535));
      2:       n_ent = 16'(MAX_ENTRIES);
      default: n_ent = 16'($urandom_range(1, 4));
    endcase
    put16(n_ent);
    // oversized directories get only a couple of entries before the end
    for (int e = 0; e < ((n_ent > 4) ? 2 : n_ent); e++) add_random_entry();
    pad_bytes($urandom_range(0, 3));
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, img.size()) : 0;
  endtask

  // ---------------------------------------------------------------- channel drivers

  // send the first len bytes of the file (all for 0), end_of_file on the last one
  task automatic send_file(input int len);
    int n;
    n = (len <= 0 || len > img.size()) ? img.size() : len;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < tx_idle) begin
        in_chan.valid <= 1'b0;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle) @(negedge clk);
      end
      in_chan.valid       <= 1'b1;
      in_chan.data_byte   <= img[k];
      in_chan.end_of_file <= (k == n - 1);
      // the transfer happens at the first rising edge with ready high
      do @(posedge clk); while (!in_chan.ready);
      @(negedge clk);
    end
  endtask

  // wait until every awaited result has come out, then let the pipeline drain
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (open_verdicts != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // setup then access phase; upper data bits are don't-care for the 8-bit registers
  task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
    logic [23:0] upper;
    upper = 24'($urandom());
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << REG_SEL_BIT;
    cfg_pwdata  <= {upper, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_range(input logic [7:0] lo, input logic [7:0] hi);
    write_reg(REG_MIN_RATING, lo);
    write_reg(REG_MAX_RATING, hi);
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    int         cut;
    int         files_out;
    logic [7:0] lo;
    logic [7:0] hi;

    in_chan.valid       = 1'b0;
    in_chan.data_byte   = '0;
    in_chan.end_of_file = 1'b0;
    out_chan.ready      = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    hold_go             = 1'b0;
    tx_idle             = 12;
    rx_idle             = 79;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed files against the reset range 0..5

    // little endian, directory right after the header, rating ends the file
    start_header(1'b1, FIRST_IFD);
    put16(16'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd3);
    send_file(0);
    // big endian, two skipped bytes, rating as a short in the second entry
    start_header(1'b0, 32'd10);
    put8(8'h00);
    put8(8'hFF);
    put16(16'd2);
    add_entry(16'h0112, TYPE_SHORT, 32'd1, 32'd1);
    add_entry(RATING_TAG, TYPE_SHORT, 32'd1, 32'd5);
    pad_bytes(2);
    send_file(0);
    // huge long is out of range so the scan goes on; entries after the hit are not examined
    start_header(1'b1, 32'd9);
    pad_bytes(1);
    put16(16'd3);
    add_entry(RATING_TAG, TYPE_LONG, 32'd1, 32'h8000_0005);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd4);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd0);
    send_file(0);
    // value count other than one
    start_header(1'b0, FIRST_IFD);
    put16(16'd2);
    add_entry(RATING_TAG, TYPE_SHORT, 32'd2, 32'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd1);
    send_file(0);
    // unknown type decides ahead of a later good entry
    start_header(1'b1, FIRST_IFD);
    put16(16'd2);
    add_entry(RATING_TAG, 16'd2, 32'd1, 32'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd1);
    send_file(0);
    // no tag: swapped tag, all-ones tag, value above the range
    start_header(1'b0, FIRST_IFD);
    put16(16'd3);
    add_entry(16'h4647, TYPE_BYTE, 32'd1, 32'd1);
    add_entry(16'hFFFF, TYPE_BYTE, 32'd1, 32'd1);
    add_entry(RATING_TAG, TYPE_LONG, 32'd1, 32'd6);
    send_file(0);
    // mixed byte-order mark, trailing bytes ignored up to the end
    start_header(1'b1, FIRST_IFD);
    img[1] = 8'h4D;
    pad_bytes(4);
    send_file(0);
    // ifd offset inside the header, once with trailing bytes and once ending on byte 7
    start_header(1'b1, 32'd7);
    pad_bytes(3);
    send_file(0);
    start_header(1'b0, 32'd0);
    send_file(0);
    // entry count zero, just above the limit, and all ones
    start_header(1'b1, FIRST_IFD);
    put16(16'd0);
    send_file(0);
    start_header(1'b0, FIRST_IFD);
    put16(16'(MAX_ENTRIES + 1));
    pad_bytes(2);
    send_file(0);
    start_header(1'b1, FIRST_IFD);
    put16(16'hFFFF);
    send_file(0);
    // count right at the limit, file ends inside the second entry
    start_header(1'b0, FIRST_IFD);
    put16(16'(MAX_ENTRIES));
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd2);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd2);
    send_file(30);
    // offset far past the end, file ends while skipping
    start_header(1'b1, 32'hFFFF_FFFF);
    pad_bytes(5);
    send_file(0);
    // single-byte file, then a file ending right after a good magic
    img.delete();
    put8(8'hFF);
    send_file(0);
    start_header(1'b1, FIRST_IFD);
    send_file(4);
    // bad magic on the final byte gives bad magic, not truncation
    start_header(1'b0, FIRST_IFD);
    img[3] = 8'h2B;
    send_file(4);

    // widest range: byte 200 is above 127, long 127 hits
    settle();
    set_range(8'h80, 8'h7F);
    start_header(1'b1, FIRST_IFD);
    put16(16'd2);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd200);
    add_entry(RATING_TAG, TYPE_LONG, 32'd1, 32'd127);
    send_file(0);
    start_header(1'b0, FIRST_IFD);
    put16(16'd1);
    add_entry(RATING_TAG, TYPE_SHORT, 32'd1, 32'd0);
    send_file(0);
    // inverted range accepts nothing
    settle();
    set_range(8'h7F, 8'h80);
    start_header(1'b1, FIRST_IFD);
    put16(16'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd0);
    send_file(0);
    // both at -128: byte 0x80 decodes unsigned as 128
    settle();
    set_range(8'h80, 8'h80);
    start_header(1'b0, FIRST_IFD);
    put16(16'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'h80);
    send_file(0);
    // both at 127
    settle();
    set_range(8'h7F, 8'h7F);
    start_header(1'b1, FIRST_IFD);
    put16(16'd1);
    add_entry(RATING_TAG, TYPE_BYTE, 32'd1, 32'd127);
    send_file(0);

    // random files in three idle regimes, a new range every quarter
    for (int regime = 0; regime < 3; regime++) begin
      for (int quarter = 0; quarter < 4; quarter++) begin
        settle();
        case (regime)
          0: begin
            tx_idle = 12;
            rx_idle = 79;
          end
          1: begin
            tx_idle = 79;
            rx_idle = 12;
          end
          default: begin
            tx_idle = 0;
            rx_idle = 0;
          end
        endcase
        case ($urandom_range(0, 5))
          0: begin
            lo = 8'h00;
            hi = 8'h05;
          end
          1: begin
            lo = 8'h80;
            hi = 8'h7F;
          end
          2: begin
            lo = 8'h7F;
            hi = 8'h80;
          end
          3: begin
            lo = 8'h80;
            hi = 8'h80;
          end
          4: begin
            lo = 8'h7F;
            hi = 8'h7F;
          end
          default: begin
            lo = 8'($urandom());
            hi = 8'($urandom());
          end
        endcase
        set_range(lo, hi);
        // full-rate sender against a stalled receiver fills the result buffer
        if (regime == 2 && quarter == 0) hold_go = 1'b1;
        files_out = 0;
        // three files under the hold-off: two results fill the buffer, the third stalls
        while (files_out < ((regime == 2 && quarter == 0) ? 3 : 1)) begin
          build_random_file(cut);
          files_out++;
          send_file(cut);
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== tiff_ifd_rating_tag_scanner_unit.f =====
hw/rtl/tifrt_pkg.sv
hw/rtl/tifrt_if.sv
hw/rtl/tiff_ifd_rating_tag_scanner_unit.sv
dv/tifrt_scan_checker.sv
dv/testbench.sv
